// ----- src/s2b_pkg.sv -----
// Package for the space-to-batch address generator.
// Holds the shared types, constants and the multiply-add helper. Depends on nothing.
package s2b_pkg;

  localparam int LAYOUT_NCHW_DEF = 0;
  localparam int DIM_MAX_DEF     = 4096;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int DIM_W   = 13;
  localparam int ADDR_W  = 5;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  typedef enum logic [2:0] {
    REG_IN_BATCH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_WIDTH    = 3'd2,
    REG_CHAN_COUNT  = 3'd3,
    REG_OUT_HEIGHT  = 3'd4,
    REG_OUT_WIDTH   = 3'd5,
    REG_BLOCK_SHAPE = 3'd6,
    REG_PAD_START   = 3'd7
  } s2b_reg_t;

  typedef struct packed {
    logic [15:0] out_b;
    logic [11:0] out_row;
    logic [11:0] out_col;
    logic [11:0] chan;
  } s2b_in_t;

  typedef struct packed {
    logic        is_pad;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
  } s2b_out_t;

  // Effective configuration after clamping and zero handling.
  typedef struct packed {
    logic [15:0]      ib;
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] cc;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] ow;
    logic [7:0]       bh;
    logic [7:0]       bw;
    logic [15:0]      pt;
    logic [15:0]      pl;
  } s2b_cfg_t;

  typedef struct packed {
    s2b_in_t     coord;
    logic [15:0] src_b;
  } s2b_side2_t;

  typedef struct packed {
    s2b_in_t     coord;
    logic [15:0] src_b;
    logic [15:0] sh;
    logic [7:0]  sw;
  } s2b_task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } s2b_qstat_t;

  function automatic logic [31:0] s2b_mac(input logic [31:0] r, input logic [DIM_W-1:0] d,
                                          input logic [31:0] a);
    logic [31:0] p;
    p = 32'(r * {19'd0, d});
    return p + a;
  endfunction

endpackage

// ----- src/s2b_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
// Depends on nothing.
module s2b_div #(
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W:0]    vld;
  logic [NUM_W-1:0]  qn [NUM_W+1];
  logic [DEN_W-1:0]  rm [NUM_W+1];
  logic [SIDE_W-1:0] sd [NUM_W+1];

  assign vld[0] = in_vld;
  assign qn[0]  = num;
  assign rm[0]  = '0;
  assign sd[0]  = side;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rm[s], qn[s][NUM_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      // shift the dividend out at the top, the quotient bit in at the bottom
      qn[s+1] <= {qn[s][NUM_W-2:0], ge};
      rm[s+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sd[s+1] <= sd[s];
    end
  end

  assign out_vld  = vld[NUM_W];
  assign quo      = qn[NUM_W];
  assign rem      = rm[NUM_W];
  assign out_side = sd[NUM_W];

endmodule

// ----- src/s2b_front.sv -----
// Front end: splits the output batch into source batch and block shifts.
// Depends on s2b_pkg and s2b_div.
module s2b_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  s2b_pkg::s2b_in_t    cmd,
  input  s2b_pkg::s2b_cfg_t   cfg,
  output logic                push,
  output s2b_pkg::s2b_task_t  push_data
);

  logic                 d1_vld;
  logic [15:0]          d1_quo;
  logic [15:0]          d1_rem;
  s2b_pkg::s2b_in_t     d1_side;
  s2b_pkg::s2b_side2_t  d2_in_side;
  s2b_pkg::s2b_side2_t  d2_side;
  logic [15:0]          d2_quo;
  logic [7:0]           d2_rem;

  // out_b / in_batch: quotient feeds the block split, remainder is the source batch
  s2b_div #(.NUM_W(16), .DEN_W(16), .SIDE_W($bits(s2b_pkg::s2b_in_t))) u_div_batch (
    .clk(clk), .rst(rst), .in_vld(accept), .num(cmd.out_b), .den(cfg.ib), .side(cmd),
    .out_vld(d1_vld), .quo(d1_quo), .rem(d1_rem), .out_side(d1_side)
  );

  assign d2_in_side.coord = d1_side;
  assign d2_in_side.src_b = d1_rem;

  // quotient / block width: row shift and column shift
  s2b_div #(.NUM_W(16), .DEN_W(8), .SIDE_W($bits(s2b_pkg::s2b_side2_t))) u_div_block (
    .clk(clk), .rst(rst), .in_vld(d1_vld), .num(d1_quo), .den(cfg.bw), .side(d2_in_side),
    .out_vld(push), .quo(d2_quo), .rem(d2_rem), .out_side(d2_side)
  );

  assign push_data.coord = d2_side.coord;
  assign push_data.src_b = d2_side.src_b;
  assign push_data.sh    = d2_quo;
  assign push_data.sw    = d2_rem;

endmodule

// ----- src/s2b_queue.sv -----
// Small FIFO between the front and back ends.
// Depends on s2b_pkg.
module s2b_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  s2b_pkg::s2b_task_t  push_data,
  input  logic                pop,
  output s2b_pkg::s2b_task_t  pop_data,
  output s2b_pkg::s2b_qstat_t stat
);

  s2b_pkg::s2b_task_t              mem [s2b_pkg::QDEPTH];
  logic [s2b_pkg::QPTR_W-1:0]      wr_ptr;
  logic [s2b_pkg::QPTR_W-1:0]      rd_ptr;
  logic [s2b_pkg::QPTR_W:0]        count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (s2b_pkg::QPTR_W + 1)'(push) - (s2b_pkg::QPTR_W + 1)'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.full  = count == (s2b_pkg::QPTR_W + 1)'(s2b_pkg::QDEPTH);
  assign stat.empty = count == '0;

endmodule

// ----- src/s2b_back.sv -----
// Back end: block position, padding test and the two flat offsets.
// Depends on s2b_pkg.
module s2b_back #(
  parameter int LAYOUT_NCHW = s2b_pkg::LAYOUT_NCHW_DEF,
  parameter int OFFSET_BITS = s2b_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  s2b_pkg::s2b_cfg_t   cfg,
  input  s2b_pkg::s2b_qstat_t qstat,
  input  s2b_pkg::s2b_task_t  pop_data,
  output logic                pop,
  output logic                done,
  output s2b_pkg::s2b_out_t   result
);

  localparam logic [63:0] OffMask64 = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [31:0] OffMask   = OffMask64[31:0];
  localparam bit          Nchw      = (LAYOUT_NCHW != 0);

  logic               a_vld, b_vld, c_vld, d_vld, e_vld;
  s2b_pkg::s2b_task_t a_task, b_task;
  logic [20:0]        b_ph, b_pw;
  logic               c_pad, d_pad, e_pad;
  logic [31:0]        c_hs, c_ws;
  s2b_pkg::s2b_task_t c_task, d_task;
  logic [31:0]        d_src, d_dst, e_src, e_dst;
  logic [31:0]        e_ws, e_wsd;
  logic [31:0]        d_hs, d_ws;

  logic [20:0]        pt21, pl21, ph_lo, pw_lo;
  logic               pad_now;
  logic [31:0]        b_src0, c_src1, c_dst1;

  assign pop = !qstat.empty;

  assign pt21    = 21'(cfg.pt);
  assign pl21    = 21'(cfg.pl);
  assign ph_lo   = b_ph - pt21;
  assign pw_lo   = b_pw - pl21;
  assign pad_now = (b_ph < pt21) || (b_ph >= pt21 + 21'(cfg.ih)) ||
                   (b_pw < pl21) || (b_pw >= pl21 + 21'(cfg.iw));

  // first step of each offset
  always_comb begin
    if (Nchw) begin
      b_src0 = s2b_pkg::s2b_mac(32'(c_task.src_b), cfg.cc, 32'(c_task.coord.chan)) & OffMask;
      c_dst1 = s2b_pkg::s2b_mac(32'(c_task.coord.out_b), cfg.cc, 32'(c_task.coord.chan))
               & OffMask;
    end else begin
      b_src0 = s2b_pkg::s2b_mac(32'(c_task.src_b), cfg.ih, c_hs) & OffMask;
      c_dst1 = s2b_pkg::s2b_mac(32'(c_task.coord.out_b), cfg.oh, 32'(c_task.coord.out_row))
               & OffMask;
    end
    c_src1 = b_src0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      a_vld <= pop;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      done  <= e_vld;
    end
    // padded source position
    a_task <= pop_data;
    b_task <= a_task;
    b_ph   <= 21'(a_task.coord.out_row) * 21'(cfg.bh) + 21'(a_task.sh);
    b_pw   <= 21'(a_task.coord.out_col) * 21'(cfg.bw) + 21'(a_task.sw);
    // padding window test
    c_task <= b_task;
    c_pad  <= pad_now;
    c_hs   <= 32'(ph_lo);
    c_ws   <= 32'(pw_lo);
    // step one of the offsets
    d_task <= c_task;
    d_pad  <= c_pad;
    d_hs   <= c_hs;
    d_ws   <= c_ws;
    d_src  <= c_src1;
    d_dst  <= c_dst1;
    // step two
    e_pad  <= d_pad;
    if (Nchw) begin
      e_src <= s2b_pkg::s2b_mac(d_src, cfg.ih, d_hs) & OffMask;
      e_dst <= s2b_pkg::s2b_mac(d_dst, cfg.oh, 32'(d_task.coord.out_row)) & OffMask;
      e_ws  <= d_ws;
      e_wsd <= 32'(d_task.coord.out_col);
    end else begin
      e_src <= s2b_pkg::s2b_mac(d_src, cfg.iw, d_ws) & OffMask;
      e_dst <= s2b_pkg::s2b_mac(d_dst, cfg.ow, 32'(d_task.coord.out_col)) & OffMask;
      e_ws  <= 32'(d_task.coord.chan);
      e_wsd <= 32'(d_task.coord.chan);
    end
    // step three, then drive the result
    result.is_pad <= e_pad;
    if (Nchw) begin
      result.src_offset <= e_pad ? 32'd0 : (s2b_pkg::s2b_mac(e_src, cfg.iw, e_ws) & OffMask);
      result.dst_offset <= s2b_pkg::s2b_mac(e_dst, cfg.ow, e_wsd) & OffMask;
    end else begin
      result.src_offset <= e_pad ? 32'd0 : (s2b_pkg::s2b_mac(e_src, cfg.cc, e_ws) & OffMask);
      result.dst_offset <= s2b_pkg::s2b_mac(e_dst, cfg.cc, e_wsd) & OffMask;
    end
  end

endmodule

// ----- src/space_to_batch_address_gen.sv -----
// Top level of the space-to-batch address generator.
// Depends on s2b_pkg, s2b_front, s2b_queue and s2b_back.
//
// Give one output coordinate per cycle with start; a command transfers when start is high and
// busy is low. Each command yields exactly one result, shown on result for one cycle with done
// high, in command order. The front end runs two 16-stage pipelined dividers (output batch by
// input batch, then the quotient by block width), then the queue, and then the back end's
// registers: queue read, block position, padding test, two multiply-add steps and the output
// register, which does the third step. The sustained rate is one item per cycle. The receiver
// cannot stall, so the back end drains the queue every cycle and busy stays low in normal
// operation; it rises only if the queue would overflow. Program the registers over the APB port
// only while no command is in flight.
module space_to_batch_address_gen #(
  parameter int LAYOUT_NCHW = s2b_pkg::LAYOUT_NCHW_DEF,
  parameter int DIM_MAX     = s2b_pkg::DIM_MAX_DEF,
  parameter int OFFSET_BITS = s2b_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  s2b_pkg::s2b_in_t            cmd,
  output logic                        done,
  output s2b_pkg::s2b_out_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [s2b_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [15:0]                in_batch;
  logic [s2b_pkg::DIM_W-1:0]  in_height, in_width, chan_count, out_height, out_width;
  logic [15:0]                block_shape;
  logic [31:0]                pad_start;

  s2b_pkg::s2b_cfg_t          cfg;
  s2b_pkg::s2b_qstat_t        qstat;
  s2b_pkg::s2b_task_t         push_data, pop_data;
  s2b_pkg::s2b_reg_t          reg_sel;
  logic                       accept, push, pop, wr_en;

  function automatic logic [s2b_pkg::DIM_W-1:0] dim_sat(input logic [s2b_pkg::DIM_W-1:0] v);
    if (32'(v) > 32'(DIM_MAX)) return s2b_pkg::DIM_W'(DIM_MAX);
    return v;
  endfunction

  assign pready  = 1'b1;
  assign reg_sel = s2b_pkg::s2b_reg_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register file: write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      in_batch    <= 16'd1;
      in_height   <= 13'd1;
      in_width    <= 13'd1;
      chan_count  <= 13'd1;
      out_height  <= 13'd1;
      out_width   <= 13'd1;
      block_shape <= 16'd257;
      pad_start   <= 32'd0;
    end else if (wr_en) begin
      case (reg_sel)
        s2b_pkg::REG_IN_BATCH:    in_batch    <= pwdata[15:0];
        s2b_pkg::REG_IN_HEIGHT:   in_height   <= pwdata[12:0];
        s2b_pkg::REG_IN_WIDTH:    in_width    <= pwdata[12:0];
        s2b_pkg::REG_CHAN_COUNT:  chan_count  <= pwdata[12:0];
        s2b_pkg::REG_OUT_HEIGHT:  out_height  <= pwdata[12:0];
        s2b_pkg::REG_OUT_WIDTH:   out_width   <= pwdata[12:0];
        s2b_pkg::REG_BLOCK_SHAPE: block_shape <= pwdata[15:0];
        s2b_pkg::REG_PAD_START:   pad_start   <= pwdata;
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (reg_sel)
      s2b_pkg::REG_IN_BATCH:    prdata = 32'(in_batch);
      s2b_pkg::REG_IN_HEIGHT:   prdata = 32'(in_height);
      s2b_pkg::REG_IN_WIDTH:    prdata = 32'(in_width);
      s2b_pkg::REG_CHAN_COUNT:  prdata = 32'(chan_count);
      s2b_pkg::REG_OUT_HEIGHT:  prdata = 32'(out_height);
      s2b_pkg::REG_OUT_WIDTH:   prdata = 32'(out_width);
      s2b_pkg::REG_BLOCK_SHAPE: prdata = 32'(block_shape);
      s2b_pkg::REG_PAD_START:   prdata = pad_start;
      default:                  prdata = 32'd0;
    endcase
  end

  // Effective settings: a zero batch count or block width acts as one, dims clamp
  assign cfg.ib = (in_batch == 16'd0) ? 16'd1 : in_batch;
  assign cfg.ih = dim_sat(in_height);
  assign cfg.iw = dim_sat(in_width);
  assign cfg.cc = dim_sat(chan_count);
  assign cfg.oh = dim_sat(out_height);
  assign cfg.ow = dim_sat(out_width);
  assign cfg.bh = block_shape[7:0];
  assign cfg.bw = (block_shape[15:8] == 8'd0) ? 8'd1 : block_shape[15:8];
  assign cfg.pt = pad_start[15:0];
  assign cfg.pl = pad_start[31:16];

  // Hold off new commands only when the queue is full
  assign busy   = qstat.full;
  assign accept = start && !busy;

  s2b_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .cmd(cmd), .cfg(cfg),
    .push(push), .push_data(push_data)
  );

  s2b_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .pop_data(pop_data), .stat(qstat)
  );

  s2b_back #(.LAYOUT_NCHW(LAYOUT_NCHW), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .qstat(qstat), .pop_data(pop_data), .pop(pop),
    .done(done), .result(result)
  );

endmodule

// ----- src/s2b_checker.sv -----
// Port-level checks for the space-to-batch address generator, bound to the top level.
// Depends on s2b_pkg and space_to_batch_address_gen.
module s2b_checker #(
  parameter int OFFSET_BITS = s2b_pkg::OFFSET_BITS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              done,
  input logic              pready,
  input s2b_pkg::s2b_out_t result
);

  // A padded destination never carries a source offset
  a_pad_src_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.is_pad |-> result.src_offset == 32'd0)
    else $error("padded result with nonzero source offset");

  // No result straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // Offsets wrap within the offset width
  a_dst_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (33'(result.dst_offset) >> OFFSET_BITS) == 33'd0)
    else $error("destination offset beyond offset width");

  a_src_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (33'(result.src_offset) >> OFFSET_BITS) == 33'd0)
    else $error("source offset beyond offset width");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind space_to_batch_address_gen s2b_checker #(.OFFSET_BITS(OFFSET_BITS)) u_s2b_checker (
  .clk(clk), .rst(rst), .done(done), .pready(pready), .result(result)
);
